>>> rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free-list block allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

	// block table geometry
	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int VOL_W      = 11;

	// null link, also the reserved header block
	localparam logic [IDX_W-1:0] NULL_LINK = '0;

	// operation codes
	localparam logic [1:0] OP_FORMAT = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_DOUBLE = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	// link memory access from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// one result word
	typedef struct packed {
		logic [IDX_W-1:0] allocated_block;
		logic [1:0]       status;
		logic [IDX_W-1:0] free_count;
	} res_t;

endpackage

>>> rtl/fla_cfg_if.sv
// ----------------------------------------------------------------------------
// fla_cfg_if
// Configuration write channel: volume size word.
// ----------------------------------------------------------------------------
interface fla_cfg_if import fla_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VOL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/fla_req_if.sv
// ----------------------------------------------------------------------------
// fla_req_if
// Request channel: operation and block index.
// ----------------------------------------------------------------------------
interface fla_req_if import fla_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       operation;
	logic [IDX_W-1:0] block_index;

	modport source (output valid, output operation, output block_index, input ready);
	modport sink (input valid, input operation, input block_index, output ready);
endinterface

>>> rtl/fla_rsp_if.sv
// ----------------------------------------------------------------------------
// fla_rsp_if
// Response channel: allocated block, status and free count.
// ----------------------------------------------------------------------------
interface fla_rsp_if import fla_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] allocated_block;
	logic [1:0]       status;
	logic [IDX_W-1:0] free_count;

	modport source (output valid, output allocated_block, output status,
		output free_count, input ready);
	modport sink (input valid, input allocated_block, input status,
		input free_count, output ready);
endinterface

>>> rtl/fla_link_mem.sv
// ----------------------------------------------------------------------------
// fla_link_mem
// Next-pointer table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fla_link_mem import fla_pkg::*; (
	input  logic             clk,
	input  mem_req_t         req,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0] mem [MAX_BLOCKS];

	// write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

>>> rtl/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl
// Sequencer: format sweep, head pop, free-list walk and push.
// ----------------------------------------------------------------------------
module fla_ctrl import fla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	fla_req_if.sink          req,
	input  logic [VOL_W-1:0] size,
	output mem_req_t         mem_o,
	input  logic [IDX_W-1:0] rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FMT   = 3'd1;
	localparam logic [2:0] S_ALLOC = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] blk_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] total_q;
	logic [IDX_W-1:0] given_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] size_m1;
	logic             accept;
	logic             blk_bad;

	assign size_m1 = size[IDX_W-1:0] - IDX_W'(1);
	assign accept  = req.valid && req.ready;
	assign blk_bad = (req.block_index == NULL_LINK) || ({1'b0, req.block_index} >= size);

	// link memory access
	always_comb begin
		mem_o       = '0;
		mem_o.raddr = head_q;
		mem_o.re    = (state_q == S_IDLE) || (state_q == S_WALK);
		unique case (state_q)
			S_IDLE: begin
				// push onto an empty list
				if (accept && req.operation == OP_FREE && !blk_bad && head_q == NULL_LINK) begin
					mem_o.we    = 1'b1;
					mem_o.waddr = req.block_index;
					mem_o.wdata = NULL_LINK;
				end
			end
			S_FMT: begin
				mem_o.we    = 1'b1;
				mem_o.waddr = idx_q;
				mem_o.wdata = (idx_q == size_m1) ? NULL_LINK : idx_q + IDX_W'(1);
			end
			S_WALK: begin
				mem_o.raddr = rdata;
				// end of list reached without a match: push
				if (rdata == NULL_LINK) begin
					mem_o.we    = 1'b1;
					mem_o.waddr = blk_q;
					mem_o.wdata = head_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			blk_q    <= '0;
			idx_q    <= '0;
			head_q   <= NULL_LINK;
			total_q  <= '0;
			given_q  <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						blk_q    <= req.block_index;
						given_q  <= '0;
						status_q <= ST_OK;
						state_q  <= S_RESP;
						unique case (req.operation)
							OP_FORMAT: begin
								if (size_m1 == '0) begin
									head_q  <= NULL_LINK;
									total_q <= '0;
								end else begin
									idx_q   <= IDX_W'(1);
									state_q <= S_FMT;
								end
							end
							OP_ALLOC: begin
								if (head_q == NULL_LINK) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_ALLOC;
								end
							end
							OP_FREE: begin
								priority if (blk_bad) begin
									status_q <= ST_RANGE;
								end else if (head_q == NULL_LINK) begin
									head_q  <= req.block_index;
									total_q <= total_q + IDX_W'(1);
								end else if (head_q == req.block_index) begin
									status_q <= ST_DOUBLE;
								end else begin
									state_q <= S_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FMT: begin
					if (idx_q == size_m1) begin
						head_q  <= IDX_W'(1);
						total_q <= size_m1;
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_ALLOC: begin
					given_q <= head_q;
					head_q  <= rdata;
					if (total_q != '0) begin
						total_q <= total_q - IDX_W'(1);
					end
					state_q <= S_RESP;
				end
				S_WALK: begin
					priority if (rdata == NULL_LINK) begin
						head_q  <= blk_q;
						total_q <= total_q + IDX_W'(1);
						state_q <= S_RESP;
					end else if (rdata == blk_q) begin
						status_q <= ST_DOUBLE;
						state_q  <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready           = (state_q == S_IDLE);
	assign res_valid           = (state_q == S_RESP);
	assign res.allocated_block = given_q;
	assign res.status          = status_q;
	assign res.free_count      = total_q;

endmodule

>>> rtl/free_list_block_allocator_core.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator_core
// Block allocator over a linked free list kept in a next-pointer memory.
//
//   channel  dir  handshake     word
//   cfg      in   valid/ready   data: volume size in blocks, header included
//   req      in   valid/ready   operation, block_index
//   rsp      out  valid/ready   allocated_block, status, free_count
//
// request steps: format writes one link per cycle through the new volume;
// allocate pops the head of the list, or answers at once on an empty list;
// a free that walks the list reads links one at a time, at most one per
// free-list entry, paced by the single read port of the link memory; a free
// answered at once (range error, empty list, hit at the head) and the unused
// code go straight to the response.
// one request word is worked at a time; the output register lets the next
// word in while a result is still stalled on rsp.
// reset clears head and count; the link memory gets no clearing pass.
// ----------------------------------------------------------------------------
module free_list_block_allocator_core import fla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fla_cfg_if.sink  cfg,
	fla_req_if.sink  req,
	fla_rsp_if.source rsp
);

	logic [VOL_W-1:0] vol_q;
	logic [VOL_W-1:0] size;
	mem_req_t         mem_req;
	logic [IDX_W-1:0] rdata;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	// volume size register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= VOL_W'(MAX_BLOCKS);
		end else if (cfg.valid && cfg.ready) begin
			vol_q <= cfg.data;
		end
	end

	// effective size: zero taken as one, clamped to the table depth
	always_comb begin
		priority if (vol_q == '0) begin
			size = VOL_W'(1);
		end else if (vol_q > VOL_W'(MAX_BLOCKS)) begin
			size = VOL_W'(MAX_BLOCKS);
		end else begin
			size = vol_q;
		end
	end

	fla_link_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	fla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.size      (size),
		.mem_o     (mem_req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.allocated_block = out_q.allocated_block;
	assign rsp.status          = out_q.status;
	assign rsp.free_count      = out_q.free_count;

	// failed requests never hand out a block
	a_fail_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.allocated_block == NULL_LINK)
		else $error("failed request returned a block");

	// a handed-out block leaves at most all but two blocks free
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.allocated_block != NULL_LINK
		|-> rsp.free_count <= IDX_W'(MAX_BLOCKS - 2))
		else $error("free count too high after allocation");

	// the request channel is not ready right after an accepted request word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted back to back");

endmodule
